[design/plpd_pkg.sv]
// Shared constants and the queue status type for the point-line projection unit.
package plpd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } plpd_qstat_t;

endpackage

[design/point_line_projection_distance_unit.sv]
// Top level of the point-to-line perpendicular projection and distance unit.
// One query (point and two line endpoints, signed fixed point) goes in per clock while
// busy is low, and one result comes out per query, in order. The depth is set by the
// pipelined divider for the squared distance (2*COORD_WIDTH+3 stages, one quotient bit
// each) followed by the square-root pipeline (COORD_WIDTH+2 stages) running alongside
// the two foot dividers. The result strobe out_valid lasts one cycle and cannot be held
// off. busy only rises if the queue between front end and arithmetic nearly fills,
// which the never-stalling back end keeps from happening.
module point_line_projection_distance_unit #(
  parameter int COORD_WIDTH = plpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_line_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_line_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_line_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_line_end_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_foot_x,
  output logic signed [COORD_WIDTH-1:0] out_foot_y,
  output logic [COORD_WIDTH-1:0]        out_distance,
  output logic                          out_degenerate,
  output logic                          out_saturated
);

  import plpd_pkg::*;

  localparam int ENT_W = 6*COORD_WIDTH + 5;
  localparam int IFW   = $clog2(4*COORD_WIDTH + 32);

  logic             accept;
  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             pop_valid;
  logic [ENT_W-1:0] pop_data;
  plpd_qstat_t      qstat;

  assign busy   = qstat.almost_full;
  assign accept = start && !busy;

  plpd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_line_start_x(in_line_start_x),
    .in_line_start_y(in_line_start_y),
    .in_line_end_x  (in_line_end_x),
    .in_line_end_y  (in_line_end_y),
    .push           (push),
    .push_data      (push_data)
  );

  plpd_queue #(.ENT_W(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_data (pop_data),
    .stat     (qstat)
  );

  plpd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pop_valid),
    .in_data       (pop_data),
    .out_valid     (out_valid),
    .out_foot_x    (out_foot_x),
    .out_foot_y    (out_foot_y),
    .out_distance  (out_distance),
    .out_degenerate(out_degenerate),
    .out_saturated (out_saturated)
  );

  // beats in flight, for checking only
  logic [IFW-1:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (accept && !out_valid) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_valid && !accept) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("queue push while full");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result without a pending query");

  a_degenerate_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (!out_saturated && out_distance == '0 && out_foot_x == '0 && out_foot_y == '0))
    else $error("degenerate result carries nonzero fields");

endmodule

[design/plpd_front.sv]
// Front end: captures a query, forms line and point offsets, flags coincident endpoints.
module plpd_front #(
  parameter int COORD_WIDTH = plpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_line_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_line_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_line_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_line_end_y,
  output logic                          push,
  output logic [6*COORD_WIDTH+4:0]      push_data
);

  localparam int W = COORD_WIDTH;

  logic signed [W:0] vx, vy, wx, wy;
  logic              deg;
  logic              valid_r;
  logic [6*W+4:0]    ent_r, ent_nxt;

  assign vx  = {in_line_end_x[W-1], in_line_end_x} - {in_line_start_x[W-1], in_line_start_x};
  assign vy  = {in_line_end_y[W-1], in_line_end_y} - {in_line_start_y[W-1], in_line_start_y};
  assign wx  = {in_point_x[W-1], in_point_x} - {in_line_start_x[W-1], in_line_start_x};
  assign wy  = {in_point_y[W-1], in_point_y} - {in_line_start_y[W-1], in_line_start_y};
  assign deg = (in_line_end_x == in_line_start_x) && (in_line_end_y == in_line_start_y);

  assign ent_nxt = {deg, in_line_start_x, in_line_start_y, vx, vy, wx, wy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

  assign push      = valid_r;
  assign push_data = ent_r;

endmodule

[design/plpd_queue.sv]
// Short FIFO between the front end and the arithmetic back end.
module plpd_queue #(
  parameter int ENT_W = 6*plpd_pkg::COORD_WIDTH_DEF+5,
  parameter int DEPTH = plpd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [ENT_W-1:0]        push_data,
  output logic                    pop_valid,
  output logic [ENT_W-1:0]        pop_data,
  output plpd_pkg::plpd_qstat_t   stat
);

  import plpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             pop;
  logic             pop_valid_r;
  logic [ENT_W-1:0] pop_data_r;

  // back end never stalls: drain whenever something is queued
  assign pop       = (count_r != '0);
  assign pop_valid = pop_valid_r;
  assign pop_data  = pop_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pop_valid_r <= 1'b0;
    end else begin
      pop_valid_r <= pop;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      pop_data_r <= mem[rd_ptr_r];
    end
  end

  plpd_qstat_t stat_w;
  assign stat_w.empty       = (count_r == '0);
  assign stat_w.full        = (count_r == CW'(DEPTH));
  assign stat_w.almost_full = (count_r >= CW'(DEPTH-1));
  assign stat               = stat_w;

endmodule

[design/plpd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with side-band payload.
module plpd_div #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int QW = 4,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          v_r   [QW];
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [SW-1:0] sd_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int I = QW - 1 - k;
    logic          v_i;
    logic [NW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] q_i;
    logic [SW-1:0] sd_i;
    logic          ge;
    logic [NW-1:0] dsh;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = num;
      assign den_i = den;
      assign q_i   = '0;
      assign sd_i  = side_in;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign q_i   = q_r[k-1];
      assign sd_i  = sd_r[k-1];
    end

    // rem >= den*2^I, tested on the shifted remainder so nothing overflows
    assign ge  = (rem_i >> I) >= NW'(den_i);
    assign dsh = NW'(den_i) << I;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_i - dsh : rem_i;
      den_r[k] <= den_i;
      q_r[k]   <= ge ? (q_i | (QW'(1) << I)) : q_i;
      sd_r[k]  <= sd_i;
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];
  assign side_out  = sd_r[QW-1];

endmodule

[design/plpd_isqrt.sv]
// Pipelined integer square root, one root bit per stage, with side-band payload.
module plpd_isqrt #(
  parameter int XW = 8,
  parameter int RW = 4,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [RW-1:0] root,
  output logic [SW-1:0] side_out
);

  localparam int TW = 2*RW + 1;

  logic          v_r    [RW];
  logic [TW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] sd_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int I = RW - 1 - k;
    logic          v_i;
    logic [TW-1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] sd_i;
    logic [TW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = TW'(x);
      assign root_i = '0;
      assign sd_i   = side_in;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sd_i   = sd_r[k-1];
    end

    // (root + 2^I)^2 - root^2 = root*2^(I+1) + 2^(2I)
    assign trial = (TW'(root_i) << (I+1)) + (TW'(1) << (2*I));
    assign ge    = rem_i >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? rem_i - trial : rem_i;
      root_r[k] <= ge ? (root_i | (RW'(1) << I)) : root_i;
      sd_r[k]   <= sd_i;
    end
  end

  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];
  assign side_out  = sd_r[RW-1];

endmodule

[design/plpd_back.sv]
// Back end: products, dot and cross terms, divisions, square root, rounding and clipping.
module plpd_back #(
  parameter int COORD_WIDTH = plpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [6*COORD_WIDTH+4:0]      in_data,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_foot_x,
  output logic signed [COORD_WIDTH-1:0] out_foot_y,
  output logic [COORD_WIDTH-1:0]        out_distance,
  output logic                          out_degenerate,
  output logic                          out_saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int H   = W + 1;
  localparam int PW  = 2*W + 2;
  localparam int NFW = 3*W + 3;
  localparam int DFW = 2*W + 3;
  localparam int NDW = 4*W + 5;
  localparam int XQW = 2*W + 3;
  localparam int RW  = W + 2;
  localparam int DSW = 2*NFW + DFW + 2*W + 3;
  localparam int FSW = W + 1;

  // unpack queue entry
  logic signed [H-1:0] vx0, vy0, wx0, wy0;
  logic signed [W-1:0] sx0, sy0;
  logic                deg0;
  assign {deg0, sx0, sy0, vx0, vy0, wx0, wy0} = in_data;

  // stage 1: six products
  logic                v1_r;
  logic signed [PW-1:0] pxx1_r, pyy1_r, pdx1_r, pdy1_r, pcx1_r, pcy1_r;
  logic signed [H-1:0]  vx1_r, vy1_r;
  logic signed [W-1:0]  sx1_r, sy1_r;
  logic                 deg1_r;

  always_ff @(posedge clk) begin
    pxx1_r <= vx0 * vx0;
    pyy1_r <= vy0 * vy0;
    pdx1_r <= wx0 * vx0;
    pdy1_r <= wy0 * vy0;
    pcx1_r <= wx0 * vy0;
    pcy1_r <= wy0 * vx0;
    vx1_r  <= vx0;
    vy1_r  <= vy0;
    sx1_r  <= sx0;
    sy1_r  <= sy0;
    deg1_r <= deg0;
  end

  // stage 2: |V|^2, dot and cross
  logic                 v2_r;
  logic [PW-1:0]        vv2_r;
  logic signed [PW:0]   dot2_r, crs2_r;
  logic signed [H-1:0]  vx2_r, vy2_r;
  logic signed [W-1:0]  sx2_r, sy2_r;
  logic                 deg2_r;

  always_ff @(posedge clk) begin
    vv2_r  <= $unsigned(pxx1_r) + $unsigned(pyy1_r);
    dot2_r <= {pdx1_r[PW-1], pdx1_r} + {pdy1_r[PW-1], pdy1_r};
    crs2_r <= {pcx1_r[PW-1], pcx1_r} - {pcy1_r[PW-1], pcy1_r};
    vx2_r  <= vx1_r;
    vy2_r  <= vy1_r;
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    deg2_r <= deg1_r;
  end

  // stage 3: magnitudes and signs
  logic                v3_r;
  logic [PW-1:0]       vv3_r, dm3_r, cm3_r;
  logic [H-1:0]        vxm3_r, vym3_r;
  logic                negx3_r, negy3_r, deg3_r;
  logic signed [W-1:0] sx3_r, sy3_r;
  logic signed [PW:0]  dot_abs, crs_abs;
  logic signed [H-1:0] vx_abs, vy_abs;

  assign dot_abs = dot2_r[PW] ? -dot2_r : dot2_r;
  assign crs_abs = crs2_r[PW] ? -crs2_r : crs2_r;
  assign vx_abs  = vx2_r[H-1] ? -vx2_r : vx2_r;
  assign vy_abs  = vy2_r[H-1] ? -vy2_r : vy2_r;

  always_ff @(posedge clk) begin
    vv3_r   <= vv2_r;
    dm3_r   <= dot_abs[PW-1:0];
    cm3_r   <= crs_abs[PW-1:0];
    vxm3_r  <= vx_abs;
    vym3_r  <= vy_abs;
    negx3_r <= vx2_r[H-1] ^ dot2_r[PW];
    negy3_r <= vy2_r[H-1] ^ dot2_r[PW];
    sx3_r   <= sx2_r;
    sy3_r   <= sy2_r;
    deg3_r  <= deg2_r;
  end

  // stage 4: partial products of |Vc|*|dot| and |cross|^2
  logic                v4_r;
  logic [PW-1:0]       axh4_r, axl4_r, ayh4_r, ayl4_r, ch24_r, chcl4_r, cl24_r, vv4_r;
  logic                negx4_r, negy4_r, deg4_r;
  logic signed [W-1:0] sx4_r, sy4_r;

  always_ff @(posedge clk) begin
    axh4_r  <= PW'(vxm3_r * dm3_r[PW-1:H]);
    axl4_r  <= PW'(vxm3_r * dm3_r[H-1:0]);
    ayh4_r  <= PW'(vym3_r * dm3_r[PW-1:H]);
    ayl4_r  <= PW'(vym3_r * dm3_r[H-1:0]);
    ch24_r  <= PW'(cm3_r[PW-1:H] * cm3_r[PW-1:H]);
    chcl4_r <= PW'(cm3_r[PW-1:H] * cm3_r[H-1:0]);
    cl24_r  <= PW'(cm3_r[H-1:0] * cm3_r[H-1:0]);
    vv4_r   <= vv3_r;
    negx4_r <= negx3_r;
    negy4_r <= negy3_r;
    sx4_r   <= sx3_r;
    sy4_r   <= sy3_r;
    deg4_r  <= deg3_r;
  end

  // stage 5: division operands; foot offset = round(num/vv) = (2num+vv) div 2vv
  logic                v5_r;
  logic [NFW-1:0]      nfx5_r, nfy5_r;
  logic [DFW-1:0]      df5_r;
  logic [NDW-1:0]      nd5_r;
  logic [PW-1:0]       vv5_r;
  logic                negx5_r, negy5_r, deg5_r;
  logic signed [W-1:0] sx5_r, sy5_r;

  always_ff @(posedge clk) begin
    nfx5_r  <= (NFW'(axh4_r) << (H+1)) + (NFW'(axl4_r) << 1) + NFW'(vv4_r);
    nfy5_r  <= (NFW'(ayh4_r) << (H+1)) + (NFW'(ayl4_r) << 1) + NFW'(vv4_r);
    df5_r   <= DFW'(vv4_r) << 1;
    nd5_r   <= (NDW'(ch24_r) << (2*H+2)) + (NDW'(chcl4_r) << (H+3)) + (NDW'(cl24_r) << 2);
    vv5_r   <= vv4_r;
    negx5_r <= negx4_r;
    negy5_r <= negy4_r;
    sx5_r   <= sx4_r;
    sy5_r   <= sy4_r;
    deg5_r  <= deg4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // 4*cross^2 / |V|^2; foot operands ride along to start their own division later
  logic           dq_v;
  logic [XQW-1:0] dq;
  logic [DSW-1:0] dq_side;
  logic [NFW-1:0] nfx6, nfy6;
  logic [DFW-1:0] df6;
  logic [W-1:0]   sx6, sy6;
  logic           negx6, negy6, deg6;

  plpd_div #(.NW(NDW), .DW(PW), .QW(XQW), .SW(DSW)) u_div_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v5_r),
    .num      (nd5_r),
    .den      (vv5_r),
    .side_in  ({nfx5_r, nfy5_r, df5_r, sx5_r, sy5_r, negx5_r, negy5_r, deg5_r}),
    .out_valid(dq_v),
    .quo      (dq),
    .side_out (dq_side)
  );

  assign {nfx6, nfy6, df6, sx6, sy6, negx6, negy6, deg6} = dq_side;

  // square root and both foot divisions share one depth
  logic           sq_v, fx_v, fy_v;
  logic [RW-1:0]  root, offx, offy;
  logic           deg7;
  logic [FSW-1:0] fx_side, fy_side;

  plpd_isqrt #(.XW(XQW), .RW(RW), .SW(1)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dq_v),
    .x        (dq),
    .side_in  (deg6),
    .out_valid(sq_v),
    .root     (root),
    .side_out (deg7)
  );

  plpd_div #(.NW(NFW), .DW(DFW), .QW(RW), .SW(FSW)) u_div_fx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dq_v),
    .num      (nfx6),
    .den      (df6),
    .side_in  ({negx6, sx6}),
    .out_valid(fx_v),
    .quo      (offx),
    .side_out (fx_side)
  );

  plpd_div #(.NW(NFW), .DW(DFW), .QW(RW), .SW(FSW)) u_div_fy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dq_v),
    .num      (nfy6),
    .den      (df6),
    .side_in  ({negy6, sy6}),
    .out_valid(fy_v),
    .quo      (offy),
    .side_out (fy_side)
  );

  // final: add offsets, round distance, clip
  logic signed [W+2:0] fx_sum, fy_sum;
  logic                fx_hi, fx_lo, fy_hi, fy_lo;
  logic [W-1:0]        fx_clip, fy_clip;
  logic [RW-1:0]       dist_rnd;
  logic                d_over;
  logic [W-1:0]        dist_clip;

  assign fx_sum = fx_side[W] ? {{3{fx_side[W-1]}}, fx_side[W-1:0]} - (W+3)'(offx)
                             : {{3{fx_side[W-1]}}, fx_side[W-1:0]} + (W+3)'(offx);
  assign fy_sum = fy_side[W] ? {{3{fy_side[W-1]}}, fy_side[W-1:0]} - (W+3)'(offy)
                             : {{3{fy_side[W-1]}}, fy_side[W-1:0]} + (W+3)'(offy);

  assign fx_hi = !fx_sum[W+2] && (fx_sum[W+1:W-1] != 3'b000);
  assign fx_lo =  fx_sum[W+2] && (fx_sum[W+1:W-1] != 3'b111);
  assign fy_hi = !fy_sum[W+2] && (fy_sum[W+1:W-1] != 3'b000);
  assign fy_lo =  fy_sum[W+2] && (fy_sum[W+1:W-1] != 3'b111);

  assign fx_clip = fx_hi ? {1'b0, {(W-1){1'b1}}} :
                   fx_lo ? {1'b1, {(W-1){1'b0}}} : fx_sum[W-1:0];
  assign fy_clip = fy_hi ? {1'b0, {(W-1){1'b1}}} :
                   fy_lo ? {1'b1, {(W-1){1'b0}}} : fy_sum[W-1:0];

  // root carries one extra bit: round half up
  assign dist_rnd  = (root >> 1) + RW'(root[0]);
  assign d_over    = (dist_rnd[RW-1:W] != '0);
  assign dist_clip = d_over ? '1 : dist_rnd[W-1:0];

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_v & fx_v & fy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (deg7) begin
      out_foot_x     <= '0;
      out_foot_y     <= '0;
      out_distance   <= '0;
      out_degenerate <= 1'b1;
      out_saturated  <= 1'b0;
    end else begin
      out_foot_x     <= fx_clip;
      out_foot_y     <= fy_clip;
      out_distance   <= dist_clip;
      out_degenerate <= 1'b0;
      out_saturated  <= fx_hi | fx_lo | fy_hi | fy_lo | d_over;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[tb/plpd_checker.sv]
// Scoreboard for the point-line projection unit: predicts each query and checks the results.
module plpd_checker #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [CW-1:0] in_point_x,
  input  logic signed [CW-1:0] in_point_y,
  input  logic signed [CW-1:0] in_line_start_x,
  input  logic signed [CW-1:0] in_line_start_y,
  input  logic signed [CW-1:0] in_line_end_x,
  input  logic signed [CW-1:0] in_line_end_y,
  input  logic                 out_valid,
  input  logic signed [CW-1:0] out_foot_x,
  input  logic signed [CW-1:0] out_foot_y,
  input  logic [CW-1:0]        out_distance,
  input  logic                 out_degenerate,
  input  logic                 out_saturated,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic [CW-1:0]        distance;
    logic                 degenerate;
    logic                 saturated;
  } projection_t;

  projection_t expected_q[$];

  initial mismatches = 0;
  assign pending = expected_q.size();

  // start + round(vc*dot/vv), halves away from zero, clipped to range
  function automatic logic signed [CW-1:0] foot_coord(input longint s, input longint vc,
                                                      input wide_t dot, input wide_t vv,
                                                      inout logic sat);
    longint hi, lo, val;
    wide_t mvc, mdot, q;
    logic neg;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    mvc = vc < 0 ? -wide_t'(vc) : wide_t'(vc);
    mdot = dot < 0 ? -dot : dot;
    neg = (vc < 0) != (dot < 0);
    q = (2 * mvc * mdot + vv) / (2 * vv);
    if (q[255:64] != 0 || q[63:0] > (64'd1 << 60)) begin
      val = neg ? lo : hi;
      sat = 1'b1;
    end else begin
      val = neg ? s - longint'(q[63:0]) : s + longint'(q[63:0]);
      if (val > hi) begin val = hi; sat = 1'b1; end
      if (val < lo) begin val = lo; sat = 1'b1; end
    end
    return val[CW-1:0];
  endfunction

  function automatic wide_t int_sqrt(input wide_t x);
    wide_t r, c;
    r = 0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if ($unsigned(c * c) <= $unsigned(x)) r = c;
    end
    return r;
  endfunction

  function automatic projection_t project(input longint px, input longint py,
                                          input longint sx, input longint sy,
                                          input longint ex, input longint ey);
    projection_t res;
    longint vx, vy, wx, wy;
    wide_t vv, dot, crs, x, r;
    logic [63:0] d;
    logic sat;
    vx = ex - sx; vy = ey - sy;
    wx = px - sx; wy = py - sy;
    vv = wide_t'(vx) * wide_t'(vx) + wide_t'(vy) * wide_t'(vy);
    res = '{default: '0};
    if (vv == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    sat = 1'b0;
    dot = wide_t'(wx) * wide_t'(vx) + wide_t'(wy) * wide_t'(vy);
    crs = wide_t'(wx) * wide_t'(vy) - wide_t'(wy) * wide_t'(vx);
    res.foot_x = foot_coord(sx, vx, dot, vv, sat);
    res.foot_y = foot_coord(sy, vy, dot, vv, sat);
    // distance carried with one extra bit, rounded half up at the end
    x = (4 * crs * crs) / vv;
    r = int_sqrt(x);
    d = (r[63:0] >> 1) + r[0];
    if (r[255:64] != 0 || d > {{(64-CW){1'b0}}, {CW{1'b1}}}) begin
      d = {{(64-CW){1'b0}}, {CW{1'b1}}};
      sat = 1'b1;
    end
    res.distance = d[CW-1:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    projection_t want;
    if (rst_n && start && !busy)
      expected_q.push_back(project(in_point_x, in_point_y, in_line_start_x,
                                   in_line_start_y, in_line_end_x, in_line_end_y));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_foot_x !== want.foot_x) report("foot_x", out_foot_x, want.foot_x);
        if (out_foot_y !== want.foot_y) report("foot_y", out_foot_y, want.foot_y);
        if (out_distance !== want.distance) report("distance", out_distance, want.distance);
        if (out_degenerate !== want.degenerate)
          report("degenerate", out_degenerate, want.degenerate);
        if (out_saturated !== want.saturated)
          report("saturated", out_saturated, want.saturated);
      end
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, query stimulus and verdict for the projection unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = plpd_pkg::COORD_WIDTH_DEF;
  localparam int LATENCY = 3 * CW + 13;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_QUERIES = 1880;

  typedef logic signed [CW-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t px = '0, py = '0, sx = '0, sy = '0, ex = '0, ey = '0;
  logic out_valid, out_degenerate, out_saturated;
  coord_t out_foot_x, out_foot_y;
  logic [CW-1:0] out_distance;
  int mismatches, pending;
  int cycles = 0;

  always #5 clk = ~clk;

  point_line_projection_distance_unit #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_line_start_x(sx), .in_line_start_y(sy),
    .in_line_end_x(ex), .in_line_end_y(ey),
    .out_valid(out_valid), .out_foot_x(out_foot_x), .out_foot_y(out_foot_y),
    .out_distance(out_distance), .out_degenerate(out_degenerate),
    .out_saturated(out_saturated)
  );

  plpd_checker #(.CW(CW)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_line_start_x(sx), .in_line_start_y(sy),
    .in_line_end_x(ex), .in_line_end_y(ey),
    .out_valid(out_valid), .out_foot_x(out_foot_x), .out_foot_y(out_foot_y),
    .out_distance(out_distance), .out_degenerate(out_degenerate),
    .out_saturated(out_saturated), .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_query(input coord_t qpx, input coord_t qpy, input coord_t qsx,
                            input coord_t qsy, input coord_t qex, input coord_t qey,
                            input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    px = qpx; py = qpy; sx = qsx; sy = qsy; ex = qex; ey = qey;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic coord_t small_val(input int bits);
    return coord_t'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  function automatic coord_t corner_val();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return coord_t'(1);
      default: return coord_t'(32'h0001_0000);
    endcase
  endfunction

  initial begin
    coord_t mn, mx, a, b, c, d, e, f;
    int gap, k;
    logic quiet;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed corners
    send_query(0, 0, 0, 0, 0, 0, 0);                 // coincident endpoints
    send_query(mx, mn, 5, 5, 5, 5, 0);
    send_query(mn, mn, mn, mn, mn, mn, 0);
    send_query(mx, mx, mx, mx, mx, mx, 0);
    send_query(0, 65536, 0, 0, 65536, 0, 0);         // horizontal line
    send_query(65536, 0, 0, 0, 0, 65536, 0);         // vertical line
    send_query(3, 3, 0, 0, 2, 2, 0);                 // point on the line
    send_query(1, 0, 0, 0, 2, 0, 0);
    send_query(1, 0, 0, 0, 2, 2, 0);                 // foot offset half, round away
    send_query(-1, 0, 0, 0, 2, 2, 0);
    send_query(0, 1, 0, 0, 2, 0, 0);                 // distance exact
    send_query(0, 1, 0, 0, 1, 1, 0);                 // distance irrational
    send_query(mx, mx, mn, mn, mx, mn, 0);           // huge distance, largest that fits
    send_query(mn, mx, mn, mn, mx, mx, 0);
    send_query(mx, mn, 0, 0, 1, 1, 0);
    send_query(mx, mx, mn, 0, mn, 1, 0);
    send_query(mx, 0, 0, 0, 1, mx, 0);               // nearly vertical line through the origin
    send_query(mn, 0, 0, 0, -1, mn, 0);
    send_query(mx, mx, mx, mn, mn, mx, 0);
    send_query(mn, mn, mx, mx, mn, mn, 0);
    send_query(mx, mn, mn, mx, mx, mn, 0);
    send_query(-1, -1, 1, -1, -1, 1, 0);

    // hold off until the pipe drains
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      if ($urandom_range(0, 99) == 0) quiet = ~quiet;
      gap = quiet ? 0 : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom; b = $urandom; c = $urandom;
          d = $urandom; e = $urandom; f = $urandom;
        end
        3, 4, 5: begin
          a = small_val(21); b = small_val(21); c = small_val(21);
          d = small_val(21); e = small_val(21); f = small_val(21);
        end
        6: begin
          a = $urandom; b = $urandom; c = $urandom; d = $urandom;
          e = c; f = d;
        end
        7: begin
          a = $urandom; b = $urandom; c = small_val(30); d = small_val(30);
          e = c + small_val(3); f = d + small_val(3);
        end
        8: begin
          a = corner_val(); b = corner_val(); c = corner_val();
          d = corner_val(); e = corner_val(); f = corner_val();
        end
        default: begin
          c = small_val(24); d = small_val(24);
          e = c + small_val(12); f = d + small_val(12);
          k = $urandom_range(0, 8) - 4;
          a = c + k * (e - c) + small_val(2);
          b = d + k * (f - d) + small_val(2);
        end
      endcase
      send_query(a, b, c, d, e, f, gap);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[point_line_projection_distance_unit.f]
design/plpd_pkg.sv
design/plpd_front.sv
design/plpd_queue.sv
design/plpd_div.sv
design/plpd_isqrt.sv
design/plpd_back.sv
design/point_line_projection_distance_unit.sv
tb/plpd_checker.sv
tb/tb.sv
